// ----- rtl/core/rrp_pkg.sv -----
// Shared types and constants for the request parser: payload structs, parse phases,
// register indexes and the token passed from the front end to the output stage.
// No dependencies.
package rrp_pkg;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_TAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_TAG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TAG   = 2'd2;

    localparam logic [7:0] RST_ARRAY_TAG = 8'd42;
    localparam logic [7:0] RST_BULK_TAG  = 8'd36;
    localparam logic [7:0] RST_END_TAG   = 8'd13;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;

    // Depth of the token queue between front end and output stage
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_ARRAY,
        PH_COUNT,
        PH_BULK,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_last;
    } t_in;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic [3:0] arg_index;
        logic       arg_end;
        logic       status;
        logic [4:0] arg_total;
    } t_out;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    // Compact token: data items carry the byte in payload; status items carry
    // {2'b0, status, arg_total} in payload.
    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [3:0] idx;
        logic       flag;
    } t_tok;

endpackage

// ----- rtl/core/resp_request_parser.sv -----
// Top level of the request parser: front end, token queue and output stage.
// Depends on rrp_pkg, rrp_front, rrp_fifo and rrp_back.
//
// One request byte is taken every clock cycle while full is low; the byte's phase
// update and the accumulator step (multiply by ten plus one digit, with a width
// check) complete in that cycle, so parsing runs at one byte per cycle. Each byte
// yields at most one result item, which enters a four-entry queue ahead of the
// output register; input keeps flowing while results wait, and full rises only
// when that queue fills. A result waits in the queue, then in the output register.
// Tag registers are written through the configuration port, which is always ready.
module resp_request_parser #(
    parameter int MAX_ARGS = 16,
    parameter int NUM_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rrp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  rrp_pkg::t_in                  i_in,
    output logic                          empty,
    input  logic                          pop,
    output rrp_pkg::t_out                 o_out
);

    rrp_pkg::t_cfg_wr cfg;
    rrp_pkg::t_tok    front_tok, queue_tok;
    logic             front_tok_valid;
    logic             accept;
    logic             queue_empty, queue_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign accept = push && !full;

    rrp_front #(
        .MAX_ARGS (MAX_ARGS),
        .NUM_BITS (NUM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_tok_valid (front_tok_valid),
        .o_tok       (front_tok)
    );

    rrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_tok_valid),
        .i_data  (front_tok),
        .i_pop   (queue_pop),
        .o_data  (queue_tok),
        .o_empty (queue_empty),
        .o_full  (full)
    );

    rrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!queue_empty),
        .i_tok       (queue_tok),
        .o_tok_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/core/rrp_front.sv -----
// Parser front end: holds the tag registers and the parse state, classifies one
// byte per accepted item and produces at most one token. Depends on rrp_pkg.
module rrp_front #(
    parameter int MAX_ARGS = 16,
    parameter int NUM_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrp_pkg::t_cfg_wr i_cfg,
    input  logic            i_accept,
    input  rrp_pkg::t_in    i_in,
    output logic            o_tok_valid,
    output rrp_pkg::t_tok   o_tok
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int CMP_W = (NUM_BITS > 9) ? NUM_BITS : 9;
    localparam logic [CMP_W-1:0] MAX_ARGS_C = CMP_W'(MAX_ARGS);

    logic [7:0] r_array_tag, r_bulk_tag, r_end_tag;

    rrp_pkg::t_phase     r_phase, n_phase;
    logic [NUM_BITS-1:0] r_acc, n_acc;
    logic                r_seen, n_seen;
    logic [CNT_W-1:0]    r_elem, n_elem;
    logic [CNT_W-1:0]    r_arg, n_arg;
    logic [NUM_BITS-1:0] r_left, n_left;
    logic                r_skip, n_skip;
    logic                r_err, n_err;

    logic [7:0]          b;
    logic                digit_ok;
    logic [NUM_BITS+3:0] prod;
    logic                overflow;
    logic [CNT_W-1:0]    arg_inc;
    logic                emit;
    logic                ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_tag <= rrp_pkg::RST_ARRAY_TAG;
            r_bulk_tag  <= rrp_pkg::RST_BULK_TAG;
            r_end_tag   <= rrp_pkg::RST_END_TAG;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rrp_pkg::CFG_ARRAY_TAG: r_array_tag <= i_cfg.data;
                rrp_pkg::CFG_BULK_TAG:  r_bulk_tag  <= i_cfg.data;
                rrp_pkg::CFG_END_TAG:   r_end_tag   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rrp_pkg::PH_ARRAY;
            r_acc   <= '0;
            r_seen  <= 1'b0;
            r_elem  <= '0;
            r_arg   <= '0;
            r_left  <= '0;
            r_skip  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_elem  <= n_elem;
            r_arg   <= n_arg;
            r_left  <= n_left;
            r_skip  <= n_skip;
            r_err   <= n_err;
        end
    end

    assign b        = i_in.data_byte;
    assign digit_ok = (b >= rrp_pkg::ASCII_ZERO) && (b <= rrp_pkg::ASCII_NINE);
    // acc * 10 + digit, with four guard bits to catch a value too wide to hold
    assign prod     = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                    + (NUM_BITS + 4)'(b - rrp_pkg::ASCII_ZERO);
    assign overflow = |prod[NUM_BITS+3:NUM_BITS];
    assign arg_inc  = r_arg + CNT_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_elem      = r_elem;
        n_arg       = r_arg;
        n_left      = r_left;
        n_skip      = r_skip;
        n_err       = r_err;
        emit        = 1'b0;
        ok          = 1'b0;
        o_tok_valid = 1'b0;
        o_tok       = '0;

        if (i_accept) begin
            if (!r_err) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    case (r_phase)
                        rrp_pkg::PH_ARRAY: begin
                            if (b != r_array_tag) begin
                                n_err = 1'b1;
                            end else begin
                                n_phase = rrp_pkg::PH_COUNT;
                                n_acc   = '0;
                                n_seen  = 1'b0;
                            end
                        end
                        rrp_pkg::PH_COUNT: begin
                            if (b == r_end_tag) begin
                                if (!r_seen || r_acc == '0
                                    || CMP_W'(r_acc) > MAX_ARGS_C) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_elem  = CNT_W'(r_acc);
                                    n_arg   = '0;
                                    n_phase = rrp_pkg::PH_BULK;
                                    n_skip  = 1'b1;
                                end
                            end else if (!digit_ok || overflow) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc  = prod[NUM_BITS-1:0];
                                n_seen = 1'b1;
                            end
                        end
                        rrp_pkg::PH_BULK: begin
                            if (b != r_bulk_tag) begin
                                n_err = 1'b1;
                            end else begin
                                n_phase = rrp_pkg::PH_LEN;
                                n_acc   = '0;
                                n_seen  = 1'b0;
                            end
                        end
                        rrp_pkg::PH_LEN: begin
                            if (b == r_end_tag) begin
                                if (!r_seen || r_acc == '0) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_left  = r_acc;
                                    n_phase = rrp_pkg::PH_DATA;
                                    n_skip  = 1'b1;
                                end
                            end else if (!digit_ok || overflow) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc  = prod[NUM_BITS-1:0];
                                n_seen = 1'b1;
                            end
                        end
                        rrp_pkg::PH_DATA: begin
                            if (b == r_end_tag) begin
                                if (r_left != '0) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_arg   = arg_inc;
                                    n_phase = (arg_inc >= r_elem) ? rrp_pkg::PH_DONE
                                                                  : rrp_pkg::PH_BULK;
                                    n_skip  = 1'b1;
                                end
                            end else if (r_left == '0) begin
                                n_err = 1'b1;
                            end else begin
                                emit   = 1'b1;
                                n_left = r_left - NUM_BITS'(1);
                            end
                        end
                        // leftover bytes after a complete message
                        default: n_err = 1'b1;
                    endcase
                end
            end

            if (i_in.msg_last) begin
                ok = !n_err && (n_phase == rrp_pkg::PH_DONE) && !n_skip;
                o_tok_valid  = 1'b1;
                o_tok.kind   = rrp_pkg::KIND_STATUS;
                o_tok.payload = {2'b00, (ok ? rrp_pkg::STATUS_OK : rrp_pkg::STATUS_ERR),
                                 5'(n_elem)};
                // start over for the next message
                n_phase = rrp_pkg::PH_ARRAY;
                n_acc   = '0;
                n_seen  = 1'b0;
                n_elem  = '0;
                n_arg   = '0;
                n_left  = '0;
                n_skip  = 1'b0;
                n_err   = 1'b0;
            end else if (emit) begin
                o_tok_valid   = 1'b1;
                o_tok.kind    = rrp_pkg::KIND_DATA;
                o_tok.payload = b;
                o_tok.idx     = 4'(r_arg);
                o_tok.flag    = (r_left == NUM_BITS'(1));
            end
        end
    end

endmodule

// ----- rtl/core/rrp_fifo.sv -----
// Short token queue between the parser front end and the output stage.
// Register array with separate read and write pointers. Depends on rrp_pkg.
module rrp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrp_pkg::t_tok i_data,
    input  logic          i_pop,
    output rrp_pkg::t_tok o_data,
    output logic          o_empty,
    output logic          o_full
);

    localparam int DEPTH = rrp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rrp_pkg::t_tok    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/rrp_back.sv -----
// Output stage: unpacks queued tokens into result items and holds the oldest one
// in an output register until it is popped. Depends on rrp_pkg.
module rrp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_valid,
    input  rrp_pkg::t_tok i_tok,
    output logic          o_tok_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output rrp_pkg::t_out o_out
);

    logic          r_valid;
    rrp_pkg::t_out r_out;
    rrp_pkg::t_out dec;

    always_comb begin
        dec = '0;
        dec.out_kind = i_tok.kind;
        if (i_tok.kind == rrp_pkg::KIND_STATUS) begin
            dec.status    = i_tok.payload[5];
            dec.arg_total = i_tok.payload[4:0];
        end else begin
            dec.out_byte  = i_tok.payload;
            dec.arg_index = i_tok.idx;
            dec.arg_end   = i_tok.flag;
        end
    end

    // refill the output register when it is free or being emptied this cycle
    assign o_tok_pop = i_tok_valid && (!r_valid || i_pop);
    assign o_empty   = !r_valid;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tok_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_out <= dec;
        end
    end

endmodule
